// ----- rtl/picaw_pkg.sv -----
package picaw_pkg;

   // Default word format: signed Q16.16.
   localparam int DEFAULT_WIDTH     = 32;
   localparam int DEFAULT_FRAC_BITS = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PROP_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTEG_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OPERATING_POINT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_LOW_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_HIGH_LIMIT  = 3'd4;

   // Where the output sits with respect to the clamp limits.
   typedef enum logic [1:0] {
      LIMIT_NONE = 2'd0,
      LIMIT_LOW  = 2'd1,
      LIMIT_HIGH = 2'd2
   } limit_state_type;

endpackage

// ----- rtl/picaw_req_if.sv -----
interface picaw_req_if
   import picaw_pkg::*;
   #(parameter int WIDTH = DEFAULT_WIDTH)
   ();

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] setpoint;
   logic signed [WIDTH-1:0] measured;

   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);

endinterface

// ----- rtl/picaw_rsp_if.sv -----
interface picaw_rsp_if
   import picaw_pkg::*;
   #(parameter int WIDTH = DEFAULT_WIDTH)
   ();

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] drive;
   limit_state_type         limit_state;

   modport source (output valid, output drive, output limit_state, input ready);
   modport sink   (input valid, input drive, input limit_state, output ready);

endinterface

// ----- rtl/picaw_csr_if.sv -----
interface picaw_csr_if
   import picaw_pkg::*;
   #(parameter int WIDTH = DEFAULT_WIDTH)
   ();

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [WIDTH-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

// ----- rtl/pi_controller_anti_windup.sv -----
// PI controller with back-calculation anti-windup: an input register, one pass of logic, a result register.
// An accepted item is captured in the input register, passes through the logic into the result register,
// and its result is offered from there.
// Throughput: one item per cycle while results are taken; the integrator loop closes within the
// single pass. A stalled result holds the result register, an empty input register takes one more
// item, then the input is held off. Reset (synchronous, active high) clears the integrator, the
// windup excess and both valid flags, and sets gains 0, operating point 0 and limits 0 to 100.0.
module pi_controller_anti_windup
   import picaw_pkg::*;
   #(
      parameter int WIDTH     = DEFAULT_WIDTH,
      parameter int FRAC_BITS = DEFAULT_FRAC_BITS
   )
   (
      input  logic        clock,
      input  logic        reset,
      picaw_req_if.sink   req_ch,
      picaw_rsp_if.source rsp_ch,
      picaw_csr_if.sink   csr_ch
   );

   localparam logic signed [WIDTH-1:0] VAL_MAX = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic signed [WIDTH-1:0] VAL_MIN = {1'b1, {(WIDTH-1){1'b0}}};
   localparam longint HUNDRED  = longint'(100) <<< FRAC_BITS;
   localparam longint VMAX_L   = longint'((65'd1 << (WIDTH-1)) - 65'd1);
   localparam logic signed [WIDTH-1:0] HIGH_RESET =
      WIDTH'((HUNDRED > VMAX_L) ? VMAX_L : HUNDRED);

   // Saturating sum of two words.
   function automatic logic signed [WIDTH-1:0] sat_add(input logic signed [WIDTH-1:0] a,
                                                        input logic signed [WIDTH-1:0] b);
      logic [WIDTH:0] s;
      s = {a[WIDTH-1], a} + {b[WIDTH-1], b};
      if (s[WIDTH] != s[WIDTH-1]) begin
         sat_add = s[WIDTH] ? VAL_MIN : VAL_MAX;
      end else begin
         sat_add = s[WIDTH-1:0];
      end
   endfunction

   // Saturating difference of two words.
   function automatic logic signed [WIDTH-1:0] sat_sub(input logic signed [WIDTH-1:0] a,
                                                        input logic signed [WIDTH-1:0] b);
      logic [WIDTH:0] s;
      s = {a[WIDTH-1], a} - {b[WIDTH-1], b};
      if (s[WIDTH] != s[WIDTH-1]) begin
         sat_sub = s[WIDTH] ? VAL_MIN : VAL_MAX;
      end else begin
         sat_sub = s[WIDTH-1:0];
      end
   endfunction

   // Configuration registers.
   logic signed [WIDTH-1:0] prop_gain_ff;
   logic signed [WIDTH-1:0] integ_gain_ff;
   logic signed [WIDTH-1:0] operating_point_ff;
   logic signed [WIDTH-1:0] low_limit_ff;
   logic signed [WIDTH-1:0] high_limit_ff;

   // Input register.
   logic                    in_valid_ff;
   logic signed [WIDTH-1:0] setpoint_ff;
   logic signed [WIDTH-1:0] measured_ff;

   // Error and gain products.
   logic signed [WIDTH-1:0] err;
   logic signed [WIDTH-1:0] prod_p;
   logic signed [WIDTH-1:0] prod_i;

   // Loop state and result register.
   logic signed [WIDTH-1:0] integ_ff;
   logic signed [WIDTH-1:0] integ_in;
   logic signed [WIDTH-1:0] excess_ff;
   logic signed [WIDTH-1:0] excess_in;
   logic signed [WIDTH-1:0] raw;
   logic                    rsp_valid_ff;
   logic signed [WIDTH-1:0] drive_ff;
   logic signed [WIDTH-1:0] drive_in;
   limit_state_type         limit_ff;
   limit_state_type         limit_in;

   // Handshakes: a register takes a new item when it is empty or passes its own on.
   logic out_ready;
   logic in_ready;
   logic out_fire;
   logic in_fire;

   assign out_ready  = !rsp_valid_ff || rsp_ch.ready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign out_fire   = in_valid_ff && out_ready;
   assign in_fire    = req_ch.valid && in_ready;

   assign req_ch.ready      = in_ready;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.drive      = drive_ff;
   assign rsp_ch.limit_state = limit_ff;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff       <= '0;
         integ_gain_ff      <= '0;
         operating_point_ff <= '0;
         low_limit_ff       <= '0;
         high_limit_ff      <= HIGH_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_PROP_GAIN:       prop_gain_ff       <= csr_ch.data;
            REG_INTEG_GAIN:      integ_gain_ff      <= csr_ch.data;
            REG_OPERATING_POINT: operating_point_ff <= csr_ch.data;
            REG_OUT_LOW_LIMIT:   low_limit_ff       <= csr_ch.data;
            REG_OUT_HIGH_LIMIT:  high_limit_ff      <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         setpoint_ff <= req_ch.setpoint;
         measured_ff <= req_ch.measured;
      end
   end

   // Control error and the two gain products; neither depends on the loop state.
   assign err = sat_sub(setpoint_ff, measured_ff);

   picaw_mul #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_prop (
      .a (prop_gain_ff),
      .b (err),
      .y (prod_p)
   );

   picaw_mul #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_integ (
      .a (integ_gain_ff),
      .b (err),
      .y (prod_i)
   );

   // Integrator update with the previous excess fed back, raw output and clamp.
   always_comb begin
      integ_in = sat_add(integ_ff, sat_sub(prod_i, excess_ff));
      raw      = sat_add(sat_add(prod_p, integ_in), operating_point_ff);
      if (raw <= low_limit_ff) begin
         drive_in = low_limit_ff;
         limit_in = LIMIT_LOW;
      end else if (raw >= high_limit_ff) begin
         drive_in = high_limit_ff;
         limit_in = LIMIT_HIGH;
      end else begin
         drive_in = raw;
         limit_in = LIMIT_NONE;
      end
      excess_in = sat_sub(raw, drive_in);
   end

   // Loop state advances only when an item moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         excess_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_fire) begin
            integ_ff  <= integ_in;
            excess_ff <= excess_in;
         end
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         drive_ff <= drive_in;
         limit_ff <= limit_in;
      end
   end

`ifndef SYNTHESIS
   // An output inside the limits leaves no windup excess behind.
   assert property (@(posedge clock) disable iff (reset)
      out_fire && (limit_in == LIMIT_NONE) |=> (excess_ff == '0))
      else $error("windup excess not cleared for an unclamped item");

   // The integrator moves only with an item entering the result register.
   assert property (@(posedge clock) disable iff (reset)
      !out_fire |=> $stable(integ_ff))
      else $error("integrator changed without an item");

   // An input register that cannot drain keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(setpoint_ff)
                                    && $stable(measured_ff))
      else $error("input register lost a stalled item");

   // A result clamped low carries the low limit that was in force.
   assert property (@(posedge clock) disable iff (reset)
      out_fire && (limit_in == LIMIT_LOW) |=> (drive_ff == $past(low_limit_ff)))
      else $error("low clamp result differs from the low limit");
`endif

endmodule

// ----- rtl/picaw_mul.sv -----
module picaw_mul
   import picaw_pkg::*;
   #(
      parameter int WIDTH     = DEFAULT_WIDTH,
      parameter int FRAC_BITS = DEFAULT_FRAC_BITS
   )
   (
      input  logic signed [WIDTH-1:0] a,
      input  logic signed [WIDTH-1:0] b,
      output logic signed [WIDTH-1:0] y
   );

   localparam logic signed [WIDTH-1:0] VAL_MAX = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic signed [WIDTH-1:0] VAL_MIN = {1'b1, {(WIDTH-1){1'b0}}};

   logic signed [2*WIDTH-1:0] prod;
   logic signed [2*WIDTH-1:0] shifted;
   logic        [WIDTH:0]     upper;

   // Full product, then an arithmetic shift, which rounds towards minus infinity.
   assign prod    = a * b;
   assign shifted = prod >>> FRAC_BITS;
   assign upper   = shifted[2*WIDTH-1:WIDTH-1];

   // The result fits when all bits above the word agree with its sign bit.
   always_comb begin
      if ((&upper) || !(|upper)) begin
         y = shifted[WIDTH-1:0];
      end else if (shifted[2*WIDTH-1]) begin
         y = VAL_MIN;
      end else begin
         y = VAL_MAX;
      end
   end

endmodule
